@@ rtl/gyro_turn_damper_top_assert.svh @@
// Assertion macros shared by the gyro turn damper RTL.
// The modules that use them must provide i_clk and i_rst_n.
`ifndef GYRO_TURN_DAMPER_TOP_ASSERT_SVH
`define GYRO_TURN_DAMPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gtd_pkg.sv @@
// Package for the gyro turn damper: widths, constants, codes, state and bus types.
// No dependencies; the modules and interfaces of the block use it.
package gtd_pkg;

    localparam int CAL_SAMPLES_DEF = 200;

    localparam int RAW_W      = 16;
    localparam int CNT_W      = 8;
    localparam int SUM_W      = 24;
    localparam int RATE_W     = 20;
    localparam int GAIN_W     = 16;
    localparam int PROD_R_W   = 27;
    localparam int PROD_D_W   = 37;
    localparam int DMP_SHIFT  = 16;
    localparam int DIV_NUM_W  = 28;
    localparam int DIV_DEN_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd3276;
    localparam logic [DIV_DEN_W-1:0] RATE_DEN   = 8'd164;
    localparam logic [DIV_DEN_W-1:0] DMP_DEN    = 8'd100;
    localparam int                   RATE_SCALE = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATE = 1'b1;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FAIL   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        DIV_OFS,
        DIV_RATE,
        DIV_DMP
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_OFS_GO,
        S_OFS_WAIT,
        S_RATE_MUL,
        S_RATE_GO,
        S_RATE_WAIT,
        S_DMP_MUL,
        S_DMP_GO,
        S_DMP_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    exec;
        logic    div_start;
        t_div_op div_op;
        logic    load_ofs;
        logic    mul_rate;
        logic    load_rate;
        logic    mul_dmp;
        logic    load_dmp;
        logic    write_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_ofs;
        logic need_rate;
        logic act_next;
        logic div_done;
    } t_dp_status;

endpackage

@@ rtl/gtd_in_if.sv @@
// Input channel of the gyro turn damper: command and raw gyro sample.
// Depends on gtd_pkg for the field widths.
interface gtd_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic signed [gtd_pkg::RAW_W-1:0]  raw_rate;

    modport source (output valid, output command, output raw_rate, input ready);
    modport sink   (input valid, input command, input raw_rate, output ready);
endinterface

@@ rtl/gtd_out_if.sv @@
// Result channel of the gyro turn damper: damping command and status flags.
// Depends on gtd_pkg for the field widths.
interface gtd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [gtd_pkg::RAW_W-1:0]  damping;
    logic                              enabled;
    logic                              calibrating;

    modport source (output valid, output damping, output enabled, output calibrating,
                    input ready);
    modport sink   (input valid, input damping, input enabled, input calibrating,
                    output ready);
endinterface

@@ rtl/gtd_div.sv @@
// Unsigned divide by the block's constant divisors through reciprocal multiplication.
// Depends on gtd_pkg and the assertion macro header.
`include "gyro_turn_damper_top_assert.svh"

module gtd_div #(
    parameter int CAL_SAMPLES = gtd_pkg::CAL_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  gtd_pkg::t_div_op                  i_op,
    input  logic [gtd_pkg::DIV_NUM_W-1:0]     i_num,
    output logic [gtd_pkg::DIV_NUM_W-1:0]     o_quot,
    output logic                              o_done
);
    import gtd_pkg::*;

    // For a dividend below 2^N and a divisor d with l = clog2(d), the product with
    // ceil(2^(N+l) / d) shifted down by N+l gives the exact floor quotient.
    localparam int OFS_N   = SUM_W;
    localparam int RATE_N  = PROD_R_W;
    localparam int DMP_N   = PROD_D_W - DMP_SHIFT;
    localparam int OFS_SH  = OFS_N + $clog2(CAL_SAMPLES);
    localparam int RATE_SH = RATE_N + $clog2(int'(RATE_DEN));
    localparam int DMP_SH  = DMP_N + $clog2(int'(DMP_DEN));
    localparam int MULT_W  = DIV_NUM_W;
    localparam int PROD_W  = DIV_NUM_W + MULT_W;

    localparam logic [MULT_W-1:0] OFS_M  = MULT_W'(((longint'(1) << OFS_SH)
                                           + longint'(CAL_SAMPLES) - 1)
                                           / longint'(CAL_SAMPLES));
    localparam logic [MULT_W-1:0] RATE_M = MULT_W'(((longint'(1) << RATE_SH)
                                           + longint'(RATE_DEN) - 1)
                                           / longint'(RATE_DEN));
    localparam logic [MULT_W-1:0] DMP_M  = MULT_W'(((longint'(1) << DMP_SH)
                                           + longint'(DMP_DEN) - 1)
                                           / longint'(DMP_DEN));

    logic                 r_busy;
    logic                 r_done;
    t_div_op              r_op;
    logic [DIV_NUM_W-1:0] r_num;
    logic [MULT_W-1:0]    r_mult;
    logic [PROD_W-1:0]    r_prod;
    logic [MULT_W-1:0]    n_mult;

    always_comb begin
        case (i_op)
            DIV_OFS:  n_mult = OFS_M;
            DIV_RATE: n_mult = RATE_M;
            DIV_DMP:  n_mult = DMP_M;
            default:  n_mult = '0;
        endcase
    end

    // Operands are registered at start and the product in the cycle after; done pulses with the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_mult <= n_mult;
            r_op   <= i_op;
        end
        if (r_busy) r_prod <= r_num * r_mult;
    end

    always_comb begin
        case (r_op)
            DIV_OFS:  o_quot = DIV_NUM_W'(r_prod >> OFS_SH);
            DIV_RATE: o_quot = DIV_NUM_W'(r_prod >> RATE_SH);
            DIV_DMP:  o_quot = DIV_NUM_W'(r_prod >> DMP_SH);
            default:  o_quot = '0;
        endcase
    end

    assign o_done = r_done;

    `GTD_ASSERT_NOW(a_start_idle, i_start, !r_busy && !r_done, "divider restarted while busy")
    `GTD_ASSERT_NEXT(a_busy_done, r_busy, r_done, "divider product not finished in time")
    `GTD_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "divider done held for two cycles")

endmodule

@@ rtl/gtd_ctrl.sv @@
// Controller of the gyro turn damper: sequences capture, update, multiplies and divides.
// Depends on gtd_pkg and the assertion macro header.
`include "gyro_turn_damper_top_assert.svh"

module gtd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gtd_pkg::t_dp_cmd    o_cmd,
    input  gtd_pkg::t_dp_status i_status
);
    import gtd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.need_ofs)       n_state = S_OFS_GO;
                else if (i_status.need_rate) n_state = S_RATE_MUL;
                else if (i_status.act_next)  n_state = S_DMP_MUL;
                else                         n_state = S_FINISH;
            end
            S_OFS_GO:    n_state = S_OFS_WAIT;
            S_OFS_WAIT: begin
                if (i_status.div_done) n_state = S_DMP_MUL;
            end
            S_RATE_MUL:  n_state = S_RATE_GO;
            S_RATE_GO:   n_state = S_RATE_WAIT;
            S_RATE_WAIT: begin
                if (i_status.div_done) n_state = S_DMP_MUL;
            end
            S_DMP_MUL:   n_state = S_DMP_GO;
            S_DMP_GO:    n_state = S_DMP_WAIT;
            S_DMP_WAIT: begin
                if (i_status.div_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.div_op = DIV_OFS;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC:      o_cmd.exec = 1'b1;
            S_OFS_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_OFS;
            end
            S_OFS_WAIT:  o_cmd.load_ofs = i_status.div_done;
            S_RATE_MUL:  o_cmd.mul_rate = 1'b1;
            S_RATE_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_RATE;
            end
            S_RATE_WAIT: o_cmd.load_rate = i_status.div_done;
            S_DMP_MUL:   o_cmd.mul_dmp = 1'b1;
            S_DMP_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_DMP;
            end
            S_DMP_WAIT:  o_cmd.load_dmp = i_status.div_done;
            S_FINISH:    o_cmd.write_out = !r_out_valid || i_out_ready;
            default:     o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.write_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    `GTD_ASSERT_NOW(a_done_in_wait, i_status.div_done, (r_state == S_OFS_WAIT) || (r_state == S_RATE_WAIT) || (r_state == S_DMP_WAIT), "divider finished outside a wait state")
    `GTD_ASSERT_NOW(a_no_overwrite, o_cmd.write_out, !r_out_valid || i_out_ready, "pending result overwritten")
    `GTD_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == S_EXEC, "accepted beat not executed")

endmodule

@@ rtl/gtd_dp.sv @@
// Datapath of the gyro turn damper: configuration, calibration state, multiplies,
// the shared divider and the result register. Depends on gtd_pkg and gtd_div.
module gtd_dp #(
    parameter int CAL_SAMPLES = gtd_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gtd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [1:0]                          i_command,
    input  logic signed [gtd_pkg::RAW_W-1:0]    i_raw_rate,
    input  gtd_pkg::t_dp_cmd                    i_cmd,
    output gtd_pkg::t_dp_status                 o_status,
    output logic signed [gtd_pkg::RAW_W-1:0]    o_damping,
    output logic                                o_enabled,
    output logic                                o_calibrating
);
    import gtd_pkg::*;

    localparam logic [CNT_W:0]       CAL_COUNT = (CNT_W + 1)'(CAL_SAMPLES);
    localparam logic signed [PROD_R_W-1:0] R_SCALE = PROD_R_W'(RATE_SCALE);
    localparam logic signed [DIV_NUM_W:0]  SAT_HI  = (DIV_NUM_W + 1)'(32767);
    localparam logic signed [DIV_NUM_W:0]  SAT_LO  = -(DIV_NUM_W + 1)'(32768);

    logic [GAIN_W-1:0]          r_gain;
    logic                       r_negate;
    logic [1:0]                 r_cmd_code;
    logic signed [RAW_W-1:0]    r_raw;
    logic                       r_active;
    logic                       r_in_cal;
    logic [CNT_W-1:0]           r_count;
    logic [SUM_W-1:0]           r_sum;
    logic signed [RAW_W-1:0]    r_offset;
    logic signed [RATE_W-1:0]   r_rate;
    logic signed [PROD_R_W-1:0] r_prod_rate;
    logic signed [PROD_D_W-1:0] r_prod_dmp;
    logic signed [RAW_W-1:0]    r_dmp;
    logic                       r_div_neg;
    logic signed [RAW_W-1:0]    r_out_damping;
    logic                       r_out_enabled;
    logic                       r_out_cal;

    logic                       is_sample;
    logic signed [RAW_W:0]      diff;
    logic signed [PROD_R_W-1:0] prod_rate_c;
    logic signed [PROD_D_W-1:0] prod_dmp_c;
    logic [SUM_W-1:0]           sum_mag;
    logic [PROD_R_W-1:0]        rate_mag;
    logic [PROD_D_W-1:0]        dmp_mag;
    logic [DIV_NUM_W-1:0]       div_num;
    logic                       div_neg;
    logic [DIV_NUM_W-1:0]       quot;
    logic                       div_done;
    logic [DIV_NUM_W:0]         q_ext;
    logic signed [DIV_NUM_W:0]  q_s;
    logic signed [RAW_W-1:0]    q_sat;

    // Status for the controller, taken from the captured beat before its update.
    assign is_sample          = (r_cmd_code == CMD_SAMPLE);
    assign o_status.need_ofs  = is_sample && r_active && r_in_cal
                                && (({1'b0, r_count} + 1'b1) >= CAL_COUNT);
    assign o_status.need_rate = is_sample && r_active && !r_in_cal;
    assign o_status.act_next  = (r_cmd_code == CMD_START) ? 1'b1
                              : (r_cmd_code == CMD_FAIL)  ? 1'b0 : r_active;
    assign o_status.div_done  = div_done;

    assign diff        = $signed({r_raw[RAW_W-1], r_raw}) - $signed({r_offset[RAW_W-1], r_offset});
    assign prod_rate_c = $signed({{(PROD_R_W-RAW_W-1){diff[RAW_W]}}, diff}) * R_SCALE;
    assign prod_dmp_c  = $signed({{(PROD_D_W-GAIN_W){1'b0}}, r_gain})
                       * $signed({{(PROD_D_W-RATE_W){r_rate[RATE_W-1]}}, r_rate});

    // Magnitudes feed the unsigned divider; the sign is restored on the quotient,
    // which gives truncation toward zero.
    assign sum_mag  = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign rate_mag = r_prod_rate[PROD_R_W-1] ? (~r_prod_rate + 1'b1) : r_prod_rate;
    assign dmp_mag  = r_prod_dmp[PROD_D_W-1] ? (~r_prod_dmp + 1'b1) : r_prod_dmp;

    always_comb begin
        case (i_cmd.div_op)
            DIV_OFS: begin
                div_num = DIV_NUM_W'(sum_mag);
                div_neg = r_sum[SUM_W-1];
            end
            DIV_RATE: begin
                div_num = DIV_NUM_W'(rate_mag);
                div_neg = r_prod_rate[PROD_R_W-1];
            end
            DIV_DMP: begin
                div_num = DIV_NUM_W'(dmp_mag[PROD_D_W-1:DMP_SHIFT]);
                div_neg = r_prod_dmp[PROD_D_W-1] ^ r_negate;
            end
            default: begin
                div_num = '0;
                div_neg = 1'b0;
            end
        endcase
    end

    gtd_div #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_op    (i_cmd.div_op),
        .i_num   (div_num),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    assign q_ext = {1'b0, quot};
    assign q_s   = $signed(r_div_neg ? (~q_ext + 1'b1) : q_ext);

    always_comb begin
        if (q_s > SAT_HI) begin
            q_sat = RAW_W'(SAT_HI);
        end else if (q_s < SAT_LO) begin
            q_sat = RAW_W'(SAT_LO);
        end else begin
            q_sat = RAW_W'(q_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_negate <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:   r_gain   <= GAIN_W'(i_cfg_data);
                CFG_NEGATE: r_negate <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_in_cal <= 1'b0;
            r_count  <= '0;
            r_sum    <= '0;
            r_offset <= '0;
            r_rate   <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_cmd_code)
                CMD_START: begin
                    r_active <= 1'b1;
                    r_in_cal <= 1'b1;
                    r_count  <= '0;
                    r_sum    <= '0;
                    r_offset <= '0;
                    r_rate   <= '0;
                end
                CMD_SAMPLE: begin
                    if (r_active && r_in_cal) begin
                        r_sum   <= r_sum + {{(SUM_W-RAW_W){r_raw[RAW_W-1]}}, r_raw};
                        r_count <= r_count + 1'b1;
                    end
                end
                CMD_FAIL: begin
                    r_active <= 1'b0;
                    r_in_cal <= 1'b0;
                    r_count  <= '0;
                    r_sum    <= '0;
                    r_offset <= '0;
                    r_rate   <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.load_ofs) begin
            r_offset <= RAW_W'(q_s);
            r_in_cal <= 1'b0;
        end else if (i_cmd.load_rate) begin
            r_rate <= RATE_W'(q_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_code <= i_command;
            r_raw      <= i_raw_rate;
        end
        if (i_cmd.mul_rate)  r_prod_rate <= prod_rate_c;
        if (i_cmd.mul_dmp)   r_prod_dmp  <= prod_dmp_c;
        if (i_cmd.div_start) r_div_neg   <= div_neg;
        if (i_cmd.load_dmp)  r_dmp       <= q_sat;
        if (i_cmd.write_out) begin
            r_out_damping <= r_active ? r_dmp : '0;
            r_out_enabled <= r_active;
            r_out_cal     <= r_in_cal;
        end
    end

    assign o_damping     = r_out_damping;
    assign o_enabled     = r_out_enabled;
    assign o_calibrating = r_out_cal;

endmodule

@@ rtl/gyro_turn_damper_top.sv @@
// Channel   Dir  Beat contents                          Accepted when
// i_in      in   command[1:0], raw_rate[15:0] signed    i_in.valid && i_in.ready
// o_out     out  damping[15:0] signed, enabled, calib   o_out.valid && o_out.ready
// i_cfg_*   in   index 0 gain_q16, index 1 negate_rate  i_cfg_we high
//
// One beat is in work at a time. A tracking sample runs one rate multiply and
// divide by 164, then one damping multiply and divide by 100. Each divide is a
// multiply by a constant reciprocal on a shared unit. The last calibration
// sample runs the divide that forms the offset, then the damping multiply and
// divide. A start, any other calibration sample, or an unused code while enabled
// runs only the damping multiply and divide; a failure or a beat while disabled
// runs neither. The result register frees the input side: the next beat is
// accepted while a result still waits, and the block only stalls if a second
// result is ready before the first was taken. Reset is synchronous and active
// low; it restores the configuration defaults and clears calibration state.
//
// Top level of the gyro turn damper; depends on gtd_pkg, the channel interfaces,
// gtd_ctrl and gtd_dp.
module gyro_turn_damper_top #(
    parameter int CAL_SAMPLES = gtd_pkg::CAL_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gtd_in_if.sink                            i_in,
    gtd_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gtd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gtd_pkg::*;

    // Command and status buses are the only link between controller and datapath.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    gtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // The datapath holds configuration, bias and rate state, and the result
    // register whose fields drive the output beat.
    gtd_dp #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_in.command),
        .i_raw_rate    (i_in.raw_rate),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_damping     (o_out.damping),
        .o_enabled     (o_out.enabled),
        .o_calibrating (o_out.calibrating)
    );

endmodule

@@ tb/sv/gtd_damping_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the gyro turn damper: tracks bias calibration, rate and damping.
// Watches the gtd_in_if / gtd_out_if channels and the register port; uses gtd_pkg.
module gtd_damping_checker #(
    parameter int CAL_SAMPLES = gtd_pkg::CAL_SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gtd_in_if                              i_in_ch,
    gtd_out_if                             i_out_ch,
    input  logic                           i_cfg_we,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gtd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import gtd_pkg::*;

    localparam longint DMP_DIVISOR = longint'(1 << DMP_SHIFT) * longint'(DMP_DEN);

    typedef struct packed {
        logic signed [RAW_W-1:0] damping;
        logic                    enabled;
        logic                    calibrating;
    } t_damp_beat;

    logic [GAIN_W-1:0]        gain_q;
    logic                     negate_q;
    logic                     trk_active;
    logic                     trk_cal;
    logic [CNT_W-1:0]         n_summed;
    logic signed [SUM_W-1:0]  bias_acc;
    logic signed [RAW_W-1:0]  bias_ofs;
    logic signed [RATE_W-1:0] rate_cdps;
    t_damp_beat               damping_due[$];
    int                       fails = 0;

    function automatic void clear_track();
        trk_active = 1'b0;
        trk_cal    = 1'b0;
        n_summed   = '0;
        bias_acc   = '0;
        bias_ofs   = '0;
        rate_cdps  = '0;
    endfunction

    function automatic logic signed [RAW_W-1:0] damping_now();
        longint d;
        if (!trk_active)
            return '0;
        d = $signed({1'b0, gain_q}) * rate_cdps;
        if (negate_q)
            d = -d;
        d = d / DMP_DIVISOR;
        if (d > 32767)
            d = 32767;
        else if (d < -32768)
            d = -32768;
        return d[RAW_W-1:0];
    endfunction

    // Applies one accepted command to the tracked state and returns the beat it must produce.
    function automatic t_damp_beat predict_damping(input logic [1:0] cmd,
                                                   input logic signed [RAW_W-1:0] raw);
        int         diff;
        t_damp_beat r;
        case (cmd)
            CMD_START: begin
                clear_track();
                trk_active = 1'b1;
                trk_cal    = 1'b1;
            end
            CMD_SAMPLE: begin
                if (trk_active && trk_cal) begin
                    bias_acc = bias_acc + raw;
                    n_summed = n_summed + 1'b1;
                    if (n_summed >= CAL_SAMPLES) begin
                        bias_ofs = int'(bias_acc) / CAL_SAMPLES;
                        trk_cal  = 1'b0;
                    end
                end else if (trk_active) begin
                    diff      = int'(raw) - int'(bias_ofs);
                    rate_cdps = (diff * RATE_SCALE) / int'(RATE_DEN);
                end
            end
            CMD_FAIL: clear_track();
            default: ;
        endcase
        r.damping     = damping_now();
        r.enabled     = trk_active;
        r.calibrating = trk_cal;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_damp_beat want;
        if (!i_rst_n) begin
            gain_q   = GAIN_RESET;
            negate_q = 1'b0;
            clear_track();
            damping_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN:   gain_q = i_cfg_data[GAIN_W-1:0];
                    CFG_NEGATE: negate_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            // A result leaving at this edge belongs to an older command, so pop first.
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (damping_due.size() == 0) begin
                    $error("result beat with nothing expected: damping %0d", i_out_ch.damping);
                    fails++;
                end else begin
                    want = damping_due.pop_front();
                    if (i_out_ch.damping !== want.damping) begin
                        $error("damping: expected %0d, got %0d", want.damping,
                               i_out_ch.damping);
                        fails++;
                    end
                    if (i_out_ch.enabled !== want.enabled) begin
                        $error("enabled: expected %0b, got %0b", want.enabled,
                               i_out_ch.enabled);
                        fails++;
                    end
                    if (i_out_ch.calibrating !== want.calibrating) begin
                        $error("calibrating: expected %0b, got %0b", want.calibrating,
                               i_out_ch.calibrating);
                        fails++;
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                damping_due.push_back(predict_damping(i_in_ch.command, i_in_ch.raw_rate));
        end
        o_pending    <= damping_due.size();
        o_fail_count <= fails + damping_due.size() * 0;
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the gyro turn damper testbench: clock, reset, stimulus and verdict.
// Depends on gtd_pkg, the gtd_in_if / gtd_out_if channels, the block and gtd_damping_checker.
module testbench;
    import gtd_pkg::*;

    localparam int         CAL_LEN       = CAL_SAMPLES_DEF;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         MAX_IDLE      = 6;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 48;
    localparam int         RANDOM_ITEMS  = 1430;
    localparam int         PHASES        = 6;
    // Slowest run: ~1700 beats, each with the longest gap, busy time and stall, taken many times.
    localparam int         CYCLE_LIMIT   = 600000;

    // How the raw samples of one calibration or tracking stretch are shaped.
    typedef enum int {
        FILL_WIDE,
        FILL_LOW,
        FILL_HIGH,
        FILL_NEAR
    } t_fill;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;

    // When calm is set, neither side inserts idle cycles.
    bit                    calm = 1'b0;
    // Set once a full calibration has gone through since the last start or failure.
    bit                    tracking = 1'b0;
    logic signed [RAW_W-1:0] cal_center = '0;

    gtd_in_if  in_ch ();
    gtd_out_if out_ch ();

    gyro_turn_damper_top #(
        .CAL_SAMPLES (CAL_LEN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gtd_damping_checker #(
        .CAL_SAMPLES (CAL_LEN)
    ) damp_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each beat.
    initial begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Sends one beat after a random gap. Valid is left high after acceptance so that
    // a zero gap keeps it up without a drop in between.
    task automatic send_beat(input logic [1:0] cmd, input logic signed [RAW_W-1:0] raw);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.command  <= cmd;
        in_ch.raw_rate <= raw;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Holds the input side until every expected result has been taken. The checker
    // updates its count at the edge, so the first look waits for the next edge.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [GAIN_W-1:0] gain, input logic negate);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN;
        cfg_data  <= CFG_DATA_W'(gain);
        @(posedge clk);
        cfg_index <= CFG_NEGATE;
        cfg_data  <= CFG_DATA_W'(negate);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [RAW_W-1:0] pick_raw(input t_fill fill);
        case (fill)
            FILL_LOW:  return 16'sh8000;
            FILL_HIGH: return 16'sh7FFF;
            FILL_NEAR: return cal_center + RAW_W'($urandom_range(0, 255)) - RAW_W'(128);
            default:   return RAW_W'($urandom);
        endcase
    endfunction

    // A start followed by the bias samples. About one in five is cut short by a
    // failure or a fresh start somewhere inside the calibration window.
    task automatic run_calibration(inout int sent);
        t_fill fill;
        int    cut_at;
        fill       = t_fill'($urandom_range(0, 3));
        cut_at     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CAL_LEN - 1) : CAL_LEN;
        cal_center = RAW_W'($urandom);
        tracking   = 1'b0;
        send_beat(CMD_START, RAW_W'($urandom));
        sent++;
        for (int k = 0; k < cut_at; k++) begin
            send_beat(CMD_SAMPLE, pick_raw(fill));
            sent++;
        end
        if (cut_at < CAL_LEN) begin
            send_beat($urandom_range(0, 1) ? CMD_FAIL : CMD_START, RAW_W'($urandom));
            sent++;
        end else begin
            tracking = 1'b1;
        end
    endtask

    // One round of the random part: mostly tracking stretches once calibrated,
    // with occasional recalibration, stray commands and full drains.
    task automatic run_round(inout int sent);
        int         pick;
        int         burst;
        t_fill      fill;
        logic [1:0] cmd;
        calm = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (!tracking || pick < 3) begin
            run_calibration(sent);
        end else if (pick < 9) begin
            // Stray beats of any code, the unused one included; they do not count.
            repeat ($urandom_range(1, 3)) begin
                cmd = 2'($urandom_range(0, 3));
                if (cmd == CMD_START || cmd == CMD_FAIL)
                    tracking = 1'b0;
                send_beat(cmd, RAW_W'($urandom));
            end
        end else if (pick < 11) begin
            wait_drained();
        end else begin
            fill  = t_fill'($urandom_range(0, 3));
            burst = $urandom_range(10, 40);
            repeat (burst) begin
                send_beat(CMD_SAMPLE, pick_raw(fill));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int               sent;
        logic [GAIN_W-1:0] gain;
        logic             negate;

        in_ch.valid    = 1'b0;
        in_ch.command  = CMD_START;
        in_ch.raw_rate = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_GAIN;
        cfg_data       = '0;
        rst_n          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, on the reset configuration. Before any start the block is
        // disabled: samples are ignored and a failure is harmless.
        send_beat(CMD_SAMPLE, 16'sh7FFF);
        send_beat(CMD_FAIL, '0);
        send_beat(CMD_UNUSED, 16'sh5555);
        // Calibration begins; samples only add to the bias sum and damping stays zero.
        send_beat(CMD_START, '0);
        send_beat(CMD_SAMPLE, 16'sh8000);
        send_beat(CMD_SAMPLE, 16'sh7FFF);
        send_beat(CMD_UNUSED, 16'shAAAA);
        // A start while active restarts calibration from cleared state.
        send_beat(CMD_START, 16'shFFFF);
        send_beat(CMD_SAMPLE, 16'sh5555);
        send_beat(CMD_SAMPLE, 16'shAAAA);
        // A failure mid-calibration disables the block; later samples are ignored.
        send_beat(CMD_FAIL, '0);
        send_beat(CMD_SAMPLE, 16'shFFFF);
        send_beat(CMD_FAIL, 16'sh7FFF);
        send_beat(CMD_SAMPLE, '0);

        // Random part in phases. The configuration only changes once the block has
        // drained; calibration state carries over from one phase to the next.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    gain   = '1;
                    negate = 1'b0;
                end
                1: begin
                    gain   = '0;
                    negate = 1'b1;
                end
                2: begin
                    gain   = '1;
                    negate = 1'b1;
                end
                3: begin
                    gain   = GAIN_RESET;
                    negate = 1'b0;
                end
                default: begin
                    gain   = GAIN_W'($urandom);
                    negate = 1'($urandom);
                end
            endcase
            write_config(gain, negate);
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES)
                run_round(sent);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
